>>> design/aabbvc_pkg.sv
// ----------------------------------------------------------------------------
// aabbvc_pkg
// Shared types and constants for the box against view volume classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package aabbvc_pkg;

  localparam int unsigned NUM_PLANES  = 4;
  localparam int unsigned NUM_CORNERS = 8;
  localparam int unsigned NUM_AXES    = 3;

  // plane normals are Q2.14, offsets scale by 2^14 before the sum
  localparam int unsigned FRAC_BITS   = 14;
  localparam int unsigned FIELD_BITS  = 16;
  localparam int unsigned OFF_BITS    = FIELD_BITS + FRAC_BITS;

  // absolute axis differences are capped here before squaring
  localparam logic [16:0] DIFF_CAP    = 17'd65536;
  localparam int unsigned DCAP_BITS   = 17;
  localparam int unsigned SQ_BITS     = 2 * DCAP_BITS;
  localparam int unsigned D2_BITS     = SQ_BITS + 2;
  localparam int unsigned FAR_SQ_BITS = 2 * FIELD_BITS;

  localparam int unsigned CFG_IDX_BITS = 3;
  localparam int unsigned CFG_DATA_BITS = 64;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_PLANE_ZERO  = 3'd0,
    CFG_PLANE_ONE   = 3'd1,
    CFG_PLANE_TWO   = 3'd2,
    CFG_PLANE_THREE = 3'd3,
    CFG_EYE         = 3'd4,
    CFG_FAR         = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    VIS_OUTSIDE   = 2'd0,
    VIS_INTERSECT = 2'd1,
    VIS_INSIDE    = 2'd2
  } vis_t;

  // per plane summary of the eight corner signs
  typedef struct packed {
    logic all_front;
    logic all_behind;
  } plane_flags_t;

endpackage

`default_nettype wire

>>> design/aabbvc_plane_eval.sv
// ----------------------------------------------------------------------------
// aabbvc_plane_eval
// Two register stages that test the eight box corners against one plane:
// six axis products first, then the corner sums reduced to sign flags.
// ----------------------------------------------------------------------------
`default_nettype none

module aabbvc_plane_eval import aabbvc_pkg::*; #(
  parameter int unsigned COORD_BITS = 16
) (
  input  wire logic                                 clk,
  input  wire logic [CFG_DATA_BITS-1:0]             plane,
  input  wire logic [NUM_AXES-1:0][COORD_BITS-1:0]  lo,
  input  wire logic [NUM_AXES-1:0][COORD_BITS-1:0]  hi,
  output plane_flags_t                              flags_r
);

  localparam int unsigned PW = COORD_BITS + FIELD_BITS;
  localparam int unsigned SW = ((PW > OFF_BITS) ? PW : OFF_BITS) + 3;

  logic signed [PW-1:0]       prod_lo_r [NUM_AXES];
  logic signed [PW-1:0]       prod_hi_r [NUM_AXES];
  logic signed [OFF_BITS-1:0] off_r;

  logic signed [PW-1:0]       prod_lo_nxt [NUM_AXES];
  logic signed [PW-1:0]       prod_hi_nxt [NUM_AXES];
  logic [NUM_CORNERS-1:0]     pos, neg;

  always_comb begin
    logic signed [PW-1:0] n_e, lo_e, hi_e;
    for (int a = 0; a < NUM_AXES; a++) begin
      n_e  = PW'($signed(plane[a*FIELD_BITS +: FIELD_BITS]));
      lo_e = PW'($signed(lo[a]));
      hi_e = PW'($signed(hi[a]));
      prod_lo_nxt[a] = n_e * lo_e;
      prod_hi_nxt[a] = n_e * hi_e;
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < NUM_AXES; a++) begin
      prod_lo_r[a] <= prod_lo_nxt[a];
      prod_hi_r[a] <= prod_hi_nxt[a];
    end
    off_r <= {$signed(plane[NUM_AXES*FIELD_BITS +: FIELD_BITS]), {FRAC_BITS{1'b0}}};
  end

  // corner c takes hi on an axis where its bit is set
  always_comb begin
    logic signed [SW-1:0] s;
    for (int c = 0; c < NUM_CORNERS; c++) begin
      s = SW'(off_r);
      for (int a = 0; a < NUM_AXES; a++) begin
        s = s + (c[a] ? SW'(prod_hi_r[a]) : SW'(prod_lo_r[a]));
      end
      pos[c] = (s > 0);
      neg[c] = (s < 0);
    end
  end

  always_ff @(posedge clk) begin
    flags_r.all_front  <= &pos;
    flags_r.all_behind <= &neg;
  end

endmodule

`default_nettype wire

>>> design/aabb_view_volume_classify.sv
// ----------------------------------------------------------------------------
// aabb_view_volume_classify
// Classifies an axis-aligned box against four side planes, an eye point and a
// far distance held in configuration registers.
// ----------------------------------------------------------------------------
// A box is taken on every cycle that start is high (busy stays low) and its
// visibility code appears at the end of the pipeline for one cycle with out_valid.
// The four register stages are input capture, plane and axis products with
// eye differences, corner plane sums and difference squares, and the final
// distance sums with the decision. The result cannot be held off, so the
// receiver must take every strobe. Configuration registers may only be
// written while no box is in flight; cfg_ready is always high.
`default_nettype none

module aabb_view_volume_classify import aabbvc_pkg::*; #(
  parameter int unsigned COORD_BITS = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [COORD_BITS-1:0]    in_min_x,
  input  wire logic [COORD_BITS-1:0]    in_min_y,
  input  wire logic [COORD_BITS-1:0]    in_min_z,
  input  wire logic [COORD_BITS-1:0]    in_max_x,
  input  wire logic [COORD_BITS-1:0]    in_max_y,
  input  wire logic [COORD_BITS-1:0]    in_max_z,
  output logic                          out_valid,
  output logic [1:0]                    out_visibility,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

  localparam int unsigned MW = (COORD_BITS > FIELD_BITS) ? COORD_BITS : FIELD_BITS;
  localparam int unsigned DW = MW + 1;

  // configuration
  logic [CFG_DATA_BITS-1:0]          plane_r [NUM_PLANES];
  logic [NUM_AXES*FIELD_BITS-1:0]    eye_r;
  logic [FIELD_BITS-1:0]             far_r;
  logic [FAR_SQ_BITS-1:0]            far_sq_r;

  // pipeline
  logic                              v1_r, v2_r, v3_r, out_valid_r;
  logic [NUM_AXES-1:0][COORD_BITS-1:0] lo_r, hi_r;
  logic [DCAP_BITS-1:0]              dlo_r [NUM_AXES];
  logic [DCAP_BITS-1:0]              dhi_r [NUM_AXES];
  logic                              eye_in2_r, eye_in3_r;
  logic [SQ_BITS-1:0]                sqlo_r [NUM_AXES];
  logic [SQ_BITS-1:0]                sqhi_r [NUM_AXES];
  plane_flags_t                      flags [NUM_PLANES];
  logic [1:0]                        vis_r;

  logic [DCAP_BITS-1:0]              dlo_nxt [NUM_AXES];
  logic [DCAP_BITS-1:0]              dhi_nxt [NUM_AXES];
  logic                              eye_in_nxt;
  vis_t                              vis_nxt;

  assign busy           = 1'b0;
  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_visibility = vis_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < NUM_PLANES; p++) begin
        plane_r[p] <= '0;
      end
      eye_r <= '0;
      far_r <= '1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PLANE_ZERO:  plane_r[0] <= cfg_data;
        CFG_PLANE_ONE:   plane_r[1] <= cfg_data;
        CFG_PLANE_TWO:   plane_r[2] <= cfg_data;
        CFG_PLANE_THREE: plane_r[3] <= cfg_data;
        CFG_EYE:         eye_r <= cfg_data[NUM_AXES*FIELD_BITS-1:0];
        CFG_FAR:         far_r <= cfg_data[FIELD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // settles long before any box reaches the last stage
  always_ff @(posedge clk) begin
    far_sq_r <= FAR_SQ_BITS'(far_r) * FAR_SQ_BITS'(far_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= start && !busy;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  // stage 1: capture the box
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      lo_r <= {in_min_z, in_min_y, in_min_x};
      hi_r <= {in_max_z, in_max_y, in_max_x};
    end
  end

  // stage 2: eye differences, capped, and the strict eye inside test
  always_comb begin
    logic signed [DW-1:0] e, l, h, dl, dh;
    logic [DW-1:0]        al, ah;
    eye_in_nxt = 1'b1;
    for (int a = 0; a < NUM_AXES; a++) begin
      e  = DW'($signed(eye_r[a*FIELD_BITS +: FIELD_BITS]));
      l  = DW'($signed(lo_r[a]));
      h  = DW'($signed(hi_r[a]));
      dl = e - l;
      dh = e - h;
      al = dl[DW-1] ? DW'(-dl) : DW'(dl);
      ah = dh[DW-1] ? DW'(-dh) : DW'(dh);
      dlo_nxt[a] = (al > DW'(DIFF_CAP)) ? DIFF_CAP : al[DCAP_BITS-1:0];
      dhi_nxt[a] = (ah > DW'(DIFF_CAP)) ? DIFF_CAP : ah[DCAP_BITS-1:0];
      eye_in_nxt = eye_in_nxt && (e > l) && (e < h);
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < NUM_AXES; a++) begin
      dlo_r[a] <= dlo_nxt[a];
      dhi_r[a] <= dhi_nxt[a];
    end
    eye_in2_r <= eye_in_nxt;
  end

  // stage 3: squares
  always_ff @(posedge clk) begin
    for (int a = 0; a < NUM_AXES; a++) begin
      sqlo_r[a] <= SQ_BITS'(dlo_r[a]) * SQ_BITS'(dlo_r[a]);
      sqhi_r[a] <= SQ_BITS'(dhi_r[a]) * SQ_BITS'(dhi_r[a]);
    end
    eye_in3_r <= eye_in2_r;
  end

  // stages 2 and 3 of the plane path run alongside
  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
    aabbvc_plane_eval #(
      .COORD_BITS (COORD_BITS)
    ) u_plane (
      .clk     (clk),
      .plane   (plane_r[p]),
      .lo      (lo_r),
      .hi      (hi_r),
      .flags_r (flags[p])
    );
  end

  // stage 4: distance sums and the decision
  always_comb begin
    logic [D2_BITS-1:0] d2;
    logic               all_near, all_far, any_front, all_behind;
    all_near = 1'b1;
    all_far  = 1'b1;
    for (int c = 0; c < NUM_CORNERS; c++) begin
      d2 = '0;
      for (int a = 0; a < NUM_AXES; a++) begin
        d2 = d2 + (c[a] ? D2_BITS'(sqhi_r[a]) : D2_BITS'(sqlo_r[a]));
      end
      all_near = all_near && (d2 < D2_BITS'(far_sq_r));
      all_far  = all_far  && (d2 > D2_BITS'(far_sq_r));
    end
    any_front  = 1'b0;
    all_behind = 1'b1;
    for (int p = 0; p < NUM_PLANES; p++) begin
      any_front  = any_front  || flags[p].all_front;
      all_behind = all_behind && flags[p].all_behind;
    end
    if (any_front) begin
      vis_nxt = VIS_OUTSIDE;
    end else if (eye_in3_r) begin
      vis_nxt = VIS_INTERSECT;
    end else if (all_far) begin
      vis_nxt = VIS_OUTSIDE;
    end else if (all_near && all_behind) begin
      vis_nxt = VIS_INSIDE;
    end else begin
      vis_nxt = VIS_INTERSECT;
    end
  end

  always_ff @(posedge clk) begin
    vis_r <= vis_nxt;
  end

`ifndef SYNTHESIS
  // every accepted box gives exactly one result strobe
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##4 out_valid)
    else $error("accepted box produced no result strobe");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 4))
    else $error("result strobe without an accepted box");

  a_vis_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_visibility == VIS_OUTSIDE || out_visibility == VIS_INTERSECT ||
                   out_visibility == VIS_INSIDE))
    else $error("unused visibility code driven");

  a_far_sq: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (far_sq_r == FAR_SQ_BITS'($past(far_r)) * FAR_SQ_BITS'($past(far_r))))
    else $error("far distance square out of step with register");
`endif

endmodule

`default_nettype wire

>>> sim/aabb_view_volume_classify_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// aabb_view_volume_classify_tb
// Drives boxes into the view volume classifier under several plane, eye and
// far distance settings, predicts each visibility code and checks every
// result strobe against the oldest prediction still waiting.
// ----------------------------------------------------------------------------

module aabb_view_volume_classify_tb;
  import aabbvc_pkg::*;

  localparam int COORD_BITS = 16;
  localparam int QUIET_LIMIT = 1000;
  localparam int ITEMS_PER_PHASE = 170;
  localparam int AXIS_UNIT = 16384;
  // indexes past the register list, writes there must change nothing
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] min_x;
    logic signed [COORD_BITS-1:0] min_y;
    logic signed [COORD_BITS-1:0] min_z;
    logic signed [COORD_BITS-1:0] max_x;
    logic signed [COORD_BITS-1:0] max_y;
    logic signed [COORD_BITS-1:0] max_z;
  } box_t;

  class visibility_checker;
    logic [63:0] plane_regs [NUM_PLANES];
    logic [47:0] eye_reg;
    logic [15:0] far_reg;
    vis_t expected_vis [$];
    int failures;

    function new();
      for (int k = 0; k < NUM_PLANES; k++) plane_regs[k] = '0;
      eye_reg = '0;
      far_reg = 16'hFFFF;
      failures = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [63:0] data);
      case (idx)
        CFG_PLANE_ZERO, CFG_PLANE_ONE, CFG_PLANE_TWO, CFG_PLANE_THREE: begin
          plane_regs[idx[1:0]] = data;
        end
        CFG_EYE: eye_reg = data[47:0];
        CFG_FAR: far_reg = data[15:0];
        default: ;
      endcase
    endfunction

    function longint capped_gap(longint a, longint b);
      longint d;
      d = (a > b) ? a - b : b - a;
      return (d > longint'(DIFF_CAP)) ? longint'(DIFF_CAP) : d;
    endfunction

    function vis_t classify_box(box_t b);
      longint lo [3], hi [3], eye [3], cx [8], cy [8], cz [8];
      longint nx, ny, nz, off, s, far_sq, dx, dy, dz, d2;
      int side_cnt, behind_planes, near_cnt;
      lo[0] = b.min_x; lo[1] = b.min_y; lo[2] = b.min_z;
      hi[0] = b.max_x; hi[1] = b.max_y; hi[2] = b.max_z;
      for (int a = 0; a < 3; a++) eye[a] = longint'($signed(eye_reg[16*a +: 16]));
      // corner order: bit 0 picks max x, bit 2 min y, bit 1 min z
      for (int i = 0; i < NUM_CORNERS; i++) begin
        cx[i] = (i & 1) ? hi[0] : lo[0];
        cy[i] = (i & 4) ? lo[1] : hi[1];
        cz[i] = (i & 2) ? lo[2] : hi[2];
      end
      behind_planes = 0;
      for (int j = 0; j < NUM_PLANES; j++) begin
        nx = longint'($signed(plane_regs[j][15:0]));
        ny = longint'($signed(plane_regs[j][31:16]));
        nz = longint'($signed(plane_regs[j][47:32]));
        off = longint'($signed(plane_regs[j][63:48])) * AXIS_UNIT;
        side_cnt = 0;
        for (int i = 0; i < NUM_CORNERS; i++) begin
          s = nx * cx[i] + ny * cy[i] + nz * cz[i] + off;
          if (s > 0) side_cnt++;
          else if (s < 0) side_cnt--;
        end
        if (side_cnt >= 8) return VIS_OUTSIDE;
        if (side_cnt <= -8) behind_planes++;
      end
      if (eye[0] > lo[0] && eye[0] < hi[0] && eye[1] > lo[1] && eye[1] < hi[1] &&
          eye[2] > lo[2] && eye[2] < hi[2]) begin
        return VIS_INTERSECT;
      end
      far_sq = longint'(far_reg) * longint'(far_reg);
      near_cnt = 0;
      for (int i = 0; i < NUM_CORNERS; i++) begin
        dx = capped_gap(eye[0], cx[i]);
        dy = capped_gap(eye[1], cy[i]);
        dz = capped_gap(eye[2], cz[i]);
        d2 = dx * dx + dy * dy + dz * dz;
        if (d2 < far_sq) near_cnt++;
        if (d2 > far_sq) near_cnt--;
      end
      if (near_cnt <= -8) return VIS_OUTSIDE;
      if (near_cnt >= 8 && behind_planes >= 4) return VIS_INSIDE;
      return VIS_INTERSECT;
    endfunction

    function void note_box(box_t b);
      expected_vis.push_back(classify_box(b));
    endfunction

    function void check_visibility(logic [1:0] got);
      vis_t want;
      if (expected_vis.size() == 0) begin
        if (failures < 10) $display("visibility %0d arrived with no box pending", got);
        failures++;
      end else begin
        want = expected_vis.pop_front();
        if (got !== want) begin
          if (failures < 10) begin
            $display("visibility mismatch: expected %0d, got %0d", want, got);
          end
          failures++;
        end
      end
    endfunction

    function int pending();
      return expected_vis.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [COORD_BITS-1:0] in_min_x = '0, in_min_y = '0, in_min_z = '0;
  logic [COORD_BITS-1:0] in_max_x = '0, in_max_y = '0, in_max_z = '0;
  logic out_valid;
  logic [1:0] out_visibility;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  visibility_checker sb = new();
  int quiet_cycles = 0;
  int vol_half;
  int eye_c [3];
  int idle_by_phase [4] = '{0, 76, 0, 18};

  aabb_view_volume_classify #(.COORD_BITS(COORD_BITS)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_min_x(in_min_x), .in_min_y(in_min_y), .in_min_z(in_min_z),
    .in_max_x(in_max_x), .in_max_y(in_max_y), .in_max_z(in_max_z),
    .out_valid(out_valid), .out_visibility(out_visibility),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_visibility(out_visibility);
  end

  // any transfer on any channel counts as progress
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  function automatic int rand_between(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic box_t make_box(int x0, int y0, int z0, int x1, int y1, int z1);
    box_t b;
    b.min_x = 16'(x0); b.min_y = 16'(y0); b.min_z = 16'(z0);
    b.max_x = 16'(x1); b.max_y = 16'(y1); b.max_z = 16'(z1);
    return b;
  endfunction

  function automatic logic [63:0] axis_plane(int nx, int ny, int nz, int off);
    return {16'(off), 16'(nz), 16'(ny), 16'(nx)};
  endfunction

  function automatic box_t random_box();
    int kind, span, t;
    int lo_v [3], hi_v [3];
    kind = $urandom_range(99);
    span = vol_half + vol_half / 4;
    for (int a = 0; a < 3; a++) begin
      lo_v[a] = rand_between(-span, span);
      hi_v[a] = lo_v[a] + rand_between(0, vol_half / 2);
      if (kind >= 60 && kind < 75) begin
        t = lo_v[a]; lo_v[a] = hi_v[a]; hi_v[a] = t;
      end else if (kind >= 75 && kind < 90) begin
        lo_v[a] = int'($signed(16'($urandom)));
        hi_v[a] = int'($signed(16'($urandom)));
      end else if (kind >= 90) begin
        // boundary values and near misses around the eye
        case ($urandom_range(5))
          0: lo_v[a] = -32768;
          1: lo_v[a] = 32767;
          2: lo_v[a] = -1;
          3: lo_v[a] = eye_c[a] - 1;
          4: lo_v[a] = eye_c[a];
          default: lo_v[a] = 0;
        endcase
        case ($urandom_range(5))
          0: hi_v[a] = 32767;
          1: hi_v[a] = -32768;
          2: hi_v[a] = 0;
          3: hi_v[a] = eye_c[a] + 1;
          4: hi_v[a] = eye_c[a];
          default: hi_v[a] = -1;
        endcase
      end
    end
    return make_box(lo_v[0], lo_v[1], lo_v[2], hi_v[0], hi_v[1], hi_v[2]);
  endfunction

  task automatic send_box(box_t b, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_min_x <= b.min_x; in_min_y <= b.min_y; in_min_z <= b.min_z;
    in_max_x <= b.max_x; in_max_y <= b.max_y; in_max_z <= b.max_z;
    do @(posedge clk); while (busy);
    sb.note_box(b);
  endtask

  // cfg_valid stays high across a run of writes, callers drop it after
  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic load_volume(int half, bit skewed);
    int far_d;
    vol_half = half;
    for (int a = 0; a < 3; a++) eye_c[a] = rand_between(-half, half);
    far_d = rand_between(half, (4 * half > 65535) ? 65535 : 4 * half);
    for (int k = 0; k < NUM_PLANES; k++) begin
      if (skewed && $urandom_range(1)) begin
        write_reg(3'(k), {$urandom, $urandom});
      end else begin
        write_reg(3'(k), axis_plane((k == 0) ? -AXIS_UNIT : (k == 1) ? AXIS_UNIT : 0,
                                    (k == 2) ? -AXIS_UNIT : (k == 3) ? AXIS_UNIT : 0,
                                    0, -half));
      end
    end
    write_reg(CFG_EYE, {16'($urandom), 16'(eye_c[2]), 16'(eye_c[1]), 16'(eye_c[0])});
    write_reg(CFG_FAR, {32'($urandom), 16'($urandom), 16'(far_d)});
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: every plane value is zero, so only the eye and distance tests act
    send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767), 0);
    send_box(make_box(32767, 32767, 32767, -32768, -32768, -32768), 0);
    send_box(make_box(100, 100, 100, 200, 200, 200), 0);
    drain();

    // a square tube of half width 1000 along z, eye behind it
    vol_half = 1000;
    eye_c = '{0, 0, -3000};
    write_reg(CFG_PLANE_ZERO, axis_plane(-AXIS_UNIT, 0, 0, -1000));
    write_reg(CFG_PLANE_ONE, axis_plane(AXIS_UNIT, 0, 0, -1000));
    write_reg(CFG_PLANE_TWO, axis_plane(0, -AXIS_UNIT, 0, -1000));
    write_reg(CFG_PLANE_THREE, axis_plane(0, AXIS_UNIT, 0, -1000));
    write_reg(CFG_EYE, {16'hA5A5, 16'(-3000), 16'h0000, 16'h0000});
    write_reg(CFG_FAR, {48'hFFFF_0000_1234, 16'd6000});
    write_reg(CFG_SPARE_LO, {$urandom, $urandom});
    write_reg(CFG_SPARE_HI, {$urandom, $urandom});
    cfg_valid <= 1'b0;
    send_box(make_box(-100, -100, -100, 100, 100, 100), 0);
    send_box(make_box(1500, -100, -100, 1600, 100, 100), 0);
    send_box(make_box(900, -100, -100, 1100, 100, 100), 0);
    // corners sitting exactly on a plane
    send_box(make_box(500, -100, -100, 1000, 100, 100), 0);
    send_box(make_box(-10, -10, -3010, 10, 10, -2990), 0);
    send_box(make_box(-100, -100, 4000, 100, 100, 4500), 0);
    // corners exactly at the far distance
    send_box(make_box(0, 0, 2990, 0, 0, 3000), 0);
    send_box(make_box(0, 0, 0, 0, 0, 0), 0);
    send_box(make_box(100, 100, 100, -100, -100, -100), 0);
    send_box(make_box(-32768, -32768, -32768, -32768, -32768, -32768), 0);
    drain();

    write_reg(CFG_FAR, 64'd0);
    cfg_valid <= 1'b0;
    send_box(make_box(-100, -100, -100, 100, 100, 100), 0);
    send_box(make_box(0, 0, -3000, 0, 0, -3000), 0);
    drain();

    write_reg(CFG_PLANE_ZERO, {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000});
    write_reg(CFG_PLANE_ONE, {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF});
    write_reg(CFG_PLANE_TWO, {4{16'h8000}});
    write_reg(CFG_PLANE_THREE, {4{16'h7FFF}});
    write_reg(CFG_EYE, {16'hFFFF, 16'h7FFF, 16'h8000, 16'h7FFF});
    write_reg(CFG_FAR, {48'hFFFF_FFFF_FFFF, 16'hFFFF});
    cfg_valid <= 1'b0;
    send_box(make_box(-32768, -32768, -32768, -32768, -32768, -32768), 0);
    send_box(make_box(32767, 32767, 32767, 32767, 32767, 32767), 0);
    send_box(make_box(-32768, 32767, -32768, 32767, -32768, 32767), 0);
    send_box(make_box(32767, -32768, 32767, -32768, 32767, -32768), 0);

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      load_volume(rand_between(500, 12000), ph[0]);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_box(random_box(), idle_by_phase[ph]);
    end

    drain();
    repeat (4) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0d visibility results never arrived", sb.pending());
      sb.failures++;
    end
    if (sb.failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
